// ----- design/nws_pkg.sv -----
package nws_pkg;

   localparam int CAPACITY    = 64;
   localparam int COORD_WIDTH = 16;

   localparam int FIELD_W = 16;
   localparam int INDEX_W = 6;
   localparam int DIST_W  = 34;
   localparam int SUM_W   = DIST_W + 2;
   localparam int SQ_IN_W = 17;
   localparam int DIFF_W  = COORD_WIDTH + 1;
   localparam int ADDR_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W   = $clog2(CAPACITY + 1);

   localparam logic [63:0]       DIFF_LIMIT = 64'd131071;
   localparam logic [DIST_W-1:0] DIST_MAX   = '1;

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_QUERY  = 1'b1;

   localparam logic [1:0] STATUS_INSERTED = 2'd0;
   localparam logic [1:0] STATUS_FULL     = 2'd1;
   localparam logic [1:0] STATUS_FOUND    = 2'd2;
   localparam logic [1:0] STATUS_EMPTY    = 2'd3;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } point_type;

   typedef struct packed {
      logic                      req_type;
      logic signed [FIELD_W-1:0] pos_x;
      logic signed [FIELD_W-1:0] pos_y;
      logic signed [FIELD_W-1:0] pos_z;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [INDEX_W-1:0] best_index;
      logic [DIST_W-1:0]  best_dist_sq;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic take_req;
      logic issue;
      logic load_rsp;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_empty;
      logic last_addr;
      logic pipe_busy;
   } stat_type;

endpackage

// ----- design/nws_datapath.sv -----
module nws_datapath
   import nws_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  req_payload_type req_payload,
   input  cmd_type         cmd,
   output stat_type        stat,
   output rsp_payload_type rsp_payload
);

   function automatic logic [DIFF_W-1:0] abs_diff(coord_type a, coord_type b);
      logic signed [DIFF_W-1:0] d;
      d = DIFF_W'(a) - DIFF_W'(b);
      return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
   endfunction

   point_type mem [CAPACITY];

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ADDR_W-1:0] scan_addr_ff, scan_addr_in;
   point_type         origin_ff;
   point_type         new_point;
   logic              wr_en;

   // pipeline valids: read data, magnitudes, squares, distance
   logic v0_ff, v1_ff, v2_ff, v3_ff;
   logic [ADDR_W-1:0] idx0_ff, idx1_ff, idx2_ff, idx3_ff;
   point_type         rd_ff;

   logic [DIFF_W-1:0] mag_x_ff, mag_y_ff, mag_z_ff;
   logic [DIFF_W-1:0] mag_x_in, mag_y_in, mag_z_in;
   logic              over1_ff, over1_in;

   logic [SQ_IN_W-1:0] mx, my, mz;
   logic [DIST_W-1:0]  sq_x_ff, sq_y_ff, sq_z_ff;
   logic [DIST_W-1:0]  sq_x_in, sq_y_in, sq_z_in;
   logic               over2_ff;

   logic [SUM_W-1:0]  sum;
   logic [DIST_W-1:0] dist3_ff, dist3_in;

   logic              have_best_ff, have_best_in;
   logic [ADDR_W-1:0] best_idx_ff, best_idx_in;
   logic [DIST_W-1:0] best_dist_ff, best_dist_in;
   logic [1:0]        result_status_ff, result_status_in;
   logic              better;

   rsp_payload_type rsp_ff, rsp_in;

   assign new_point.x = coord_type'(req_payload.pos_x);
   assign new_point.y = coord_type'(req_payload.pos_y);
   assign new_point.z = coord_type'(req_payload.pos_z);

   always_comb begin
      count_in         = count_ff;
      scan_addr_in     = scan_addr_ff;
      wr_en            = 1'b0;
      result_status_in = result_status_ff;
      if (cmd.take_req) begin
         scan_addr_in = '0;
         if (req_payload.req_type == REQ_INSERT) begin
            if (count_ff == CNT_W'(CAPACITY)) begin
               result_status_in = STATUS_FULL;
            end else begin
               result_status_in = STATUS_INSERTED;
               wr_en            = 1'b1;
               count_in         = count_ff + 1'b1;
            end
         end else if (count_ff == '0) begin
            result_status_in = STATUS_EMPTY;
         end else begin
            result_status_in = STATUS_FOUND;
         end
      end else if (cmd.issue) begin
         scan_addr_in = scan_addr_ff + 1'b1;
      end
   end

   assign stat.is_empty  = (count_ff == '0);
   assign stat.last_addr = ((CNT_W'(scan_addr_ff) + 1'b1) == count_ff);
   assign stat.pipe_busy = v0_ff | v1_ff | v2_ff | v3_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[ADDR_W-1:0]] <= new_point;
      end
      if (cmd.issue) begin
         rd_ff <= mem[scan_addr_ff];
      end
   end

   // stage 1: absolute differences
   assign mag_x_in = abs_diff(rd_ff.x, origin_ff.x);
   assign mag_y_in = abs_diff(rd_ff.y, origin_ff.y);
   assign mag_z_in = abs_diff(rd_ff.z, origin_ff.z);
   assign over1_in = (64'(mag_x_in) > DIFF_LIMIT) || (64'(mag_y_in) > DIFF_LIMIT)
                  || (64'(mag_z_in) > DIFF_LIMIT);

   // stage 2: squares
   assign mx      = SQ_IN_W'(mag_x_ff);
   assign my      = SQ_IN_W'(mag_y_ff);
   assign mz      = SQ_IN_W'(mag_z_ff);
   assign sq_x_in = DIST_W'(mx) * DIST_W'(mx);
   assign sq_y_in = DIST_W'(my) * DIST_W'(my);
   assign sq_z_in = DIST_W'(mz) * DIST_W'(mz);

   // stage 3: sum with saturation
   assign sum      = SUM_W'(sq_x_ff) + SUM_W'(sq_y_ff) + SUM_W'(sq_z_ff);
   assign dist3_in = (over2_ff || (sum > SUM_W'(DIST_MAX))) ? DIST_MAX : DIST_W'(sum);

   // stage 4: keep the earliest strict minimum
   assign better = v3_ff && (!have_best_ff || (dist3_ff < best_dist_ff));

   always_comb begin
      have_best_in = have_best_ff;
      best_idx_in  = best_idx_ff;
      best_dist_in = best_dist_ff;
      if (cmd.take_req) begin
         have_best_in = 1'b0;
         best_idx_in  = '0;
         best_dist_in = '0;
      end else if (better) begin
         have_best_in = 1'b1;
         best_idx_in  = idx3_ff;
         best_dist_in = dist3_ff;
      end
   end

   always_comb begin
      rsp_in        = rsp_ff;
      if (cmd.load_rsp) begin
         rsp_in.status       = result_status_ff;
         rsp_in.best_index   = '0;
         rsp_in.best_dist_sq = '0;
         if (result_status_ff == STATUS_FOUND) begin
            rsp_in.best_index   = INDEX_W'(best_idx_ff);
            rsp_in.best_dist_sq = best_dist_ff;
         end
      end
   end

   assign rsp_payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         v0_ff        <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         have_best_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         v0_ff        <= cmd.issue;
         v1_ff        <= v0_ff;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         have_best_ff <= have_best_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_addr_ff     <= scan_addr_in;
      result_status_ff <= result_status_in;
      best_idx_ff      <= best_idx_in;
      best_dist_ff     <= best_dist_in;
      rsp_ff           <= rsp_in;
      if (cmd.take_req) begin
         origin_ff <= new_point;
      end
      idx0_ff  <= scan_addr_ff;
      idx1_ff  <= idx0_ff;
      idx2_ff  <= idx1_ff;
      idx3_ff  <= idx2_ff;
      mag_x_ff <= mag_x_in;
      mag_y_ff <= mag_y_in;
      mag_z_ff <= mag_z_in;
      over1_ff <= over1_in;
      sq_x_ff  <= sq_x_in;
      sq_y_ff  <= sq_y_in;
      sq_z_ff  <= sq_z_in;
      over2_ff <= over1_ff;
      dist3_ff <= dist3_in;
   end

endmodule

// ----- design/nws_ctrl.sv -----
module nws_ctrl
   import nws_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic     req_kind,
   output logic     req_stall,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.take_req = 1'b1;
               if (req_kind == REQ_INSERT || stat.is_empty) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.issue = 1'b1;
            if (stat.last_addr) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!stat.pipe_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_stall    = (state_ff != ST_IDLE);
   assign rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && rsp_stall);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- design/nearest_waypoint_search.sv -----
// insert: taken in the idle state, result loaded in the done state; no new request
// is taken until the state is idle again. query: the single memory read port visits
// one point per cycle, then a 4-stage distance/compare pipeline drains
// the result sits in an output register, so the next request is taken while it waits
// reset clears the point count and all control state; table contents stay undefined
module nearest_waypoint_search
   import nws_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   cmd_type  cmd;
   stat_type stat;

   nws_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_payload.req_type),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   nws_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_payload (rsp_payload)
   );

endmodule

// ----- sim/nearest_waypoint_search_tb.sv -----
module nearest_waypoint_search_tb;
   import nws_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef logic signed [FIELD_W-1:0] coord_field_type;

   localparam coord_field_type COORD_MIN = coord_field_type'(-(2 ** (FIELD_W - 1)));
   localparam coord_field_type COORD_MAX = coord_field_type'(2 ** (FIELD_W - 1) - 1);
   localparam int RESET_CYCLES  = 12;
   localparam int LONG_HOLD     = 400;
   localparam int DRAIN_CYCLES  = 100;
   localparam int CYCLE_LIMIT   = 800000;
   localparam int REPORT_LIMIT  = 10;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;

   // shadow copy of the waypoint table, updated by every accepted insert that finds room
   point_type       shadow_points [CAPACITY];
   int              shadow_count = 0;
   rsp_payload_type answers_due [$];

   // stimulus-side view of what has been stored, for aiming queries
   point_type       sent_points [$];

   int  mismatch_count = 0;
   int  results_checked = 0;
   int  status_seen [4] = '{0, 0, 0, 0};
   int  cycle_count = 0;

   bit  req_idling = 1'b1;
   bit  rsp_idling = 1'b1;
   int  hold_request = 0;
   int  hold_seen = 0;
   int  hold_left = 0;
   int  stall_run_left = 0;
   bit  stall_run_high = 1'b0;

   nearest_waypoint_search dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("run stopped after %0d cycles with %0d results outstanding",
                  cycle_count, answers_due.size());
         $display("[nearest_waypoint_search] ERROR");
         $finish;
      end
   end

   // insert or look up, returning the answer the block must give
   function automatic rsp_payload_type apply_request(input req_payload_type item);
      rsp_payload_type ans;
      longint          dx, dy, dz, d, best_d;
      ans = '0;
      best_d = 0;
      if (item.req_type == REQ_INSERT) begin
         if (shadow_count >= CAPACITY) begin
            ans.status = STATUS_FULL;
         end else begin
            shadow_points[shadow_count].x = item.pos_x;
            shadow_points[shadow_count].y = item.pos_y;
            shadow_points[shadow_count].z = item.pos_z;
            shadow_count++;
            ans.status = STATUS_INSERTED;
         end
      end else if (shadow_count == 0) begin
         ans.status = STATUS_EMPTY;
      end else begin
         for (int i = 0; i < shadow_count; i++) begin
            dx = longint'(shadow_points[i].x) - longint'(item.pos_x);
            dy = longint'(shadow_points[i].y) - longint'(item.pos_y);
            dz = longint'(shadow_points[i].z) - longint'(item.pos_z);
            d = dx * dx + dy * dy + dz * dz;
            if (d > longint'(DIST_MAX))
               d = longint'(DIST_MAX);
            // strict compare keeps the earliest point on a tie
            if (i == 0 || d < best_d) begin
               best_d = d;
               ans.best_index = INDEX_W'(i);
            end
         end
         ans.status = STATUS_FOUND;
         ans.best_dist_sq = DIST_W'(best_d);
      end
      return ans;
   endfunction

   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset) begin
         // results are checked before this edge's request is predicted
         if (rsp_valid && !rsp_stall) begin
            results_checked++;
            if (answers_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("cycle %0d: unexpected result status %0d index %0d dist %0d",
                           cycle_count, rsp_payload.status, rsp_payload.best_index,
                           rsp_payload.best_dist_sq);
            end else begin
               want = answers_due.pop_front();
               status_seen[want.status]++;
               if (rsp_payload.status != want.status
                   || rsp_payload.best_index != want.best_index
                   || rsp_payload.best_dist_sq != want.best_dist_sq) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT) begin
                     $write("cycle %0d: expected status %0d index %0d dist %0d,",
                            cycle_count, want.status, want.best_index,
                            want.best_dist_sq);
                     $display(" got status %0d index %0d dist %0d", rsp_payload.status,
                              rsp_payload.best_index, rsp_payload.best_dist_sq);
                  end
               end
            end
         end
         if (req_valid && !req_stall)
            answers_due.push_back(apply_request(req_payload));
      end
   end

   // result side: long hold on request, no stall when not idling, otherwise random stall bursts
   always @(posedge clock) begin
      if (hold_request != hold_seen) begin
         hold_seen = hold_request;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!rsp_idling) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_run_left == 0) begin
            stall_run_high = ($urandom_range(0, 2) == 0);
            if (!stall_run_high)
               stall_run_left = $urandom_range(1, 8);
            else if ($urandom_range(0, 9) == 0)
               stall_run_left = $urandom_range(10, 40);
            else
               stall_run_left = $urandom_range(1, 3);
         end
         stall_run_left--;
         rsp_stall <= stall_run_high;
      end
   end

   function automatic int pick_gap();
      int r;
      if (!req_idling)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 88)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   function automatic req_payload_type make_req(input logic kind, input coord_field_type x,
                                                input coord_field_type y,
                                                input coord_field_type z);
      req_payload_type item;
      item.req_type = kind;
      item.pos_x = x;
      item.pos_y = y;
      item.pos_z = z;
      return item;
   endfunction

   function automatic coord_field_type rand_coord();
      case ($urandom_range(0, 9))
         0: return COORD_MIN;
         1: return COORD_MAX;
         2: return coord_field_type'(int'($urandom_range(0, 2)) - 1);
         3, 4, 5: return coord_field_type'(int'($urandom_range(0, 400)) - 200);
         default: return FIELD_W'($urandom);
      endcase
   endfunction

   function automatic coord_field_type nudge(input coord_field_type c);
      int v;
      v = int'(c) + int'($urandom_range(0, 64)) - 32;
      if (v > COORD_MAX)
         v = COORD_MAX;
      if (v < COORD_MIN)
         v = COORD_MIN;
      return coord_field_type'(v);
   endfunction

   function automatic req_payload_type random_insert();
      point_type p;
      if (sent_points.size() != 0 && $urandom_range(0, 99) < 15) begin
         p = sent_points[$urandom_range(0, sent_points.size() - 1)];
         return make_req(REQ_INSERT, p.x, p.y, p.z);
      end
      return make_req(REQ_INSERT, rand_coord(), rand_coord(), rand_coord());
   endfunction

   // origins aimed at, near, or far from stored points
   function automatic req_payload_type random_query();
      point_type p;
      int        r;
      r = $urandom_range(0, 99);
      if (sent_points.size() == 0 || r < 45)
         return make_req(REQ_QUERY, rand_coord(), rand_coord(), rand_coord());
      p = sent_points[$urandom_range(0, sent_points.size() - 1)];
      if (r < 60)
         return make_req(REQ_QUERY, p.x, p.y, p.z);
      return make_req(REQ_QUERY, nudge(p.x), nudge(p.y), nudge(p.z));
   endfunction

   task automatic send_req(input req_payload_type item);
      int        gap;
      point_type p;
      if (item.req_type == REQ_INSERT && sent_points.size() < CAPACITY) begin
         p.x = item.pos_x;
         p.y = item.pos_y;
         p.z = item.pos_z;
         sent_points.push_back(p);
      end
      req_payload <= item;
      req_valid   <= 1'b1;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (answers_due.size() != 0)
         @(posedge clock);
   endtask

   task automatic test_empty_table();
      send_req(make_req(REQ_QUERY, '0, '0, '0));
      send_req(make_req(REQ_QUERY, COORD_MIN, COORD_MAX, COORD_MIN));
      wait_drained();
   endtask

   task automatic test_extreme_points();
      // single point at one corner, lookup from the opposite corner: largest distance
      send_req(make_req(REQ_INSERT, COORD_MIN, COORD_MIN, COORD_MIN));
      send_req(make_req(REQ_QUERY, COORD_MAX, COORD_MAX, COORD_MAX));
      send_req(make_req(REQ_INSERT, COORD_MAX, COORD_MAX, COORD_MAX));
      send_req(make_req(REQ_INSERT, COORD_MIN, COORD_MIN, COORD_MIN));
      send_req(make_req(REQ_INSERT, 16'sd10, '0, '0));
      send_req(make_req(REQ_INSERT, -16'sd10, '0, '0));
      send_req(make_req(REQ_INSERT, COORD_MAX, COORD_MIN, -16'sd1));
      // duplicate corner and mirrored pair both tie, earliest must win
      send_req(make_req(REQ_QUERY, COORD_MIN, COORD_MIN, COORD_MIN));
      send_req(make_req(REQ_QUERY, '0, '0, '0));
      send_req(make_req(REQ_QUERY, '0, '0, 16'sd5));
      send_req(make_req(REQ_QUERY, COORD_MAX, COORD_MIN, -16'sd1));
      send_req(make_req(REQ_QUERY, COORD_MAX, COORD_MAX, COORD_MAX));
      send_req(make_req(REQ_QUERY, COORD_MIN, COORD_MAX, 16'sd0));
      wait_drained();
   endtask

   task automatic test_random_fill(input int target_points);
      while (sent_points.size() < target_points) begin
         if ($urandom_range(0, 99) < 45)
            send_req(random_insert());
         else
            send_req(random_query());
      end
      wait_drained();
   endtask

   task automatic test_output_backpressure();
      hold_request++;
      for (int k = 0; k < 16; k++) begin
         if (k % 2 == 0)
            send_req(random_insert());
         else
            send_req(random_query());
      end
      wait_drained();
   endtask

   task automatic test_full_table(input int item_total);
      for (int k = 0; k < item_total; k++) begin
         // every third stretch runs with both sides streaming
         if (k % 120 == 0) begin
            req_idling = ((k / 120) % 3 != 1);
            rsp_idling = req_idling;
         end
         if ($urandom_range(0, 99) < 30)
            send_req(random_insert());
         else
            send_req(random_query());
      end
      wait_drained();
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_table();
      test_extreme_points();
      test_random_fill(30);
      test_output_backpressure();
      test_random_fill(CAPACITY);
      test_full_table(680);
      rsp_idling = 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("checked %0d results: %0d stored, %0d dropped on a full table,",
               results_checked, status_seen[STATUS_INSERTED], status_seen[STATUS_FULL]);
      $display("%0d nearest lookups, %0d empty-table lookups, %0d mismatches",
               status_seen[STATUS_FOUND], status_seen[STATUS_EMPTY], mismatch_count);
      if (mismatch_count == 0 && answers_due.size() == 0)
         $display("[nearest_waypoint_search] OK");
      else
         $display("[nearest_waypoint_search] ERROR");
      $finish;
   end

endmodule
